@@ rtl/byte_budget_lru_cache_top_defines.svh @@
// ----------------------------------------------------------------------------
// byte budget lru cache assertion macros
// shared immediate-free concurrent assertion forms, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define BBLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bblc assertion failed");

// consequent checked in the next cycle
`define BBLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bblc assertion failed");

`endif

@@ rtl/bblc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_pkg
// types and constants of the byte budget lru cache directory
// ----------------------------------------------------------------------------
package bblc_pkg;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  localparam logic [31:0] CAP_RESET = 32'd65536;

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [1:0] OUT_HIT    = 2'd0;
  localparam logic [1:0] OUT_INSERT = 2'd1;
  localparam logic [1:0] OUT_BYPASS = 2'd2;

  typedef struct packed {
    logic [31:0] request_key;
    logic [31:0] object_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [4:0]  evicted_count;
    logic [31:0] bytes_in_use;
    logic [4:0]  entries_in_use;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_EVICT,
    S_EV_APPLY,
    S_UPDATE,
    S_FINISH
  } state_t;

endpackage

@@ rtl/bblc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bblc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/byte_budget_lru_cache_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_top
// cache directory with a byte budget and lru replacement
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and the result shows
// on result with done for one cycle, which the receiver must take then. Done
// rises at the same edge at which busy falls, so it is high in the first
// cycle with busy low. Busy covers a lookup pass over the entry and rank
// memories, one entry per cycle; a hit or an insert adds a second pass (rank
// update and insert), and an insert adds an order memory read for each
// eviction.
// No clearing pass after reset: valid bits live in flip-flops.
module byte_budget_lru_cache_top
  import bblc_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int ENT_W     = KEY_BITS + 32;
  localparam int ORD_W     = SLOT_BITS + 32;
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ENTRIES);

  state_t state, state_next;

  logic [CNT_BITS-1:0]  cnt;
  logic [SLOT_BITS-1:0] p;
  logic                 p_vld;
  logic [KEY_BITS-1:0]  key_q;
  logic [31:0]          size_q;
  logic                 found;
  logic [SLOT_BITS-1:0] hit_idx;
  logic [SLOT_BITS-1:0] hit_rank;
  logic                 slot_done;
  logic [31:0]          used;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  evicted;
  logic [1:0]           outcome_q;
  logic [ENTRIES-1:0]   valid;
  logic [31:0]          capacity;

  logic [ENT_W-1:0]     ent_rd;
  logic [SLOT_BITS-1:0] rank_rd;
  logic [ORD_W-1:0]     ord_rd;

  logic [SLOT_BITS-1:0] addr;
  logic                 last;
  logic                 lookup_hit;
  logic [31:0]          free_b;
  logic                 fits;
  logic                 full;
  logic                 upd;
  logic                 ins;
  logic                 rank_we;
  logic [SLOT_BITS-1:0] rank_wdata;
  logic                 ent_we;
  logic                 ord_we;
  logic [SLOT_BITS-1:0] ord_raddr;
  logic [SLOT_BITS-1:0] ev_slot;
  logic [31:0]          ev_size;
  logic                 cfg_wr;

  assign addr       = cnt[SLOT_BITS-1:0];
  assign last       = (cnt == CNT_FULL);
  assign lookup_hit = p_vld && valid[p] && (ent_rd[ENT_W-1:32] == key_q) && !found;
  assign free_b     = (used >= capacity) ? 32'd0 : (capacity - used);
  assign fits       = (free_b >= size_q) || (count == '0);
  assign full       = (count == CNT_FULL);
  assign ev_slot    = ord_rd[ORD_W-1:32];
  assign ev_size    = ord_rd[31:0];
  assign ord_raddr  = SLOT_BITS'(count - CNT_BITS'(1));
  assign cfg_wr     = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? capacity : 32'd0;

  // rank update pass: hit moves to front, insert ages every valid entry
  always_comb begin
    upd        = (state == S_UPDATE) && p_vld;
    ins        = upd && !found && !valid[p] && !slot_done;
    ent_we     = ins;
    rank_we    = (upd && valid[p]) || ins;
    rank_wdata = rank_rd + SLOT_BITS'(1);
    if (ins) begin
      rank_wdata = '0;
    end else if (found) begin
      if (p == hit_idx) begin
        rank_wdata = '0;
      end else if (rank_rd >= hit_rank) begin
        rank_wdata = rank_rd;
      end
    end
    ord_we = (state == S_LOOKUP) && p_vld && valid[p];
  end

  bblc_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (p),
    .wdata ({key_q, size_q}),
    .raddr (addr),
    .rdata (ent_rd)
  );

  bblc_ram #(.WIDTH(SLOT_BITS), .DEPTH(ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (p),
    .wdata (rank_wdata),
    .raddr (addr),
    .rdata (rank_rd)
  );

  // rank to slot map, rebuilt on every lookup pass
  bblc_ram #(.WIDTH(ORD_W), .DEPTH(ENTRIES)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (rank_rd),
    .wdata ({p, ent_rd[31:0]}),
    .raddr (ord_raddr),
    .rdata (ord_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (found) begin
          state_next = S_UPDATE;
        end else if (size_q > capacity) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!fits || full) begin
          state_next = S_EV_APPLY;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_EV_APPLY: state_next = S_EVICT;
      S_UPDATE: begin
        if (last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      p_vld     <= 1'b0;
      found     <= 1'b0;
      slot_done <= 1'b0;
      used      <= '0;
      count     <= '0;
      evicted   <= '0;
      valid     <= '0;
      capacity  <= CAP_RESET;
      done      <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
        capacity <= pwdata;
      end
      done <= (state == S_FINISH);
      if (state == S_FINISH) begin
        result.outcome        <= outcome_q;
        result.evicted_count  <= 5'(evicted);
        result.bytes_in_use   <= used;
        result.entries_in_use <= 5'(count);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            key_q     <= KEY_BITS'(request.request_key);
            size_q    <= request.object_bytes;
            cnt       <= '0;
            p_vld     <= 1'b0;
            found     <= 1'b0;
            slot_done <= 1'b0;
            evicted   <= '0;
          end
        end
        S_LOOKUP: begin
          cnt   <= last ? cnt : cnt + CNT_BITS'(1);
          p_vld <= !last;
          p     <= addr;
          if (lookup_hit) begin
            found    <= 1'b1;
            hit_idx  <= p;
            hit_rank <= rank_rd;
          end
        end
        S_DECIDE: begin
          cnt   <= '0;
          p_vld <= 1'b0;
          if (found) begin
            outcome_q <= OUT_HIT;
          end else if (size_q > capacity) begin
            outcome_q <= OUT_BYPASS;
          end else begin
            outcome_q <= OUT_INSERT;
          end
        end
        S_EV_APPLY: begin
          valid[ev_slot] <= 1'b0;
          used           <= (used >= ev_size) ? (used - ev_size) : 32'd0;
          count          <= count - CNT_BITS'(1);
          evicted        <= evicted + CNT_BITS'(1);
        end
        S_UPDATE: begin
          cnt   <= last ? cnt : cnt + CNT_BITS'(1);
          p_vld <= !last;
          p     <= addr;
          if (ins) begin
            valid[p]  <= 1'b1;
            slot_done <= 1'b1;
            count     <= count + CNT_BITS'(1);
            used      <= used + size_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/bblc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_checker
// port level checks of the byte budget lru cache, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_budget_lru_cache_top_defines.svh"

module bblc_checker
  import bblc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // hits and bypasses never evict
  logic no_evict_item;
  assign no_evict_item = (result.outcome == OUT_HIT) || (result.outcome == OUT_BYPASS);

  `BBLC_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `BBLC_ASSERT_SAME(a_done_idle, done, !busy)
  `BBLC_ASSERT_NEXT(a_done_single, done, !done)
  `BBLC_ASSERT_SAME(a_no_evict, done && no_evict_item, result.evicted_count == 5'd0)

endmodule

bind byte_budget_lru_cache_top bblc_checker u_bblc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
